/* sv/slotted_value_page_defines.svh */
// assertion macros shared by the slotted value page checkers
// needs clk and rst in the scope where a macro is used
`ifndef SLOTTED_VALUE_PAGE_DEFINES_SVH
`define SLOTTED_VALUE_PAGE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define SVP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define SVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/svp_pkg.sv */
// shared types and codes for the slotted value page
// no dependencies
package svp_pkg;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 8;
  localparam int REQ_W    = 13;
  localparam int OFF_W    = 12;
  localparam int STATUS_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ALLOC,
    S_EXEC,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] level;
    logic [KEY_W-1:0] item;
    logic [OFF_W-1:0] offset;
  } slot_entry_t;

endpackage

/* sv/svp_dir_ram.sv */
// slot directory memory: one write port, one read port, registered read
// depends on svp_pkg for the entry layout
module svp_dir_ram
  import svp_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  slot_entry_t       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output slot_entry_t       rd_data
);

  slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/slotted_value_page.sv */
// slotted value page: clear, add and lookup over a slot directory in memory.
// one transaction at a time; from acceptance to out_valid a clear passes S_EXEC and
// S_RESULT, an add S_ROUND (round-up multiply), S_ALLOC (align multiply), S_EXEC (space
// check) and S_RESULT, a lookup S_EXEC, S_SCAN over stored slots at one entry per cycle, S_RESULT.
// in_ready returns in the same cycle as the result appears in the output register.
// rst clears slot count, low bound and handshakes; directory contents are not cleared.
module slotted_value_page
  import svp_pkg::*;
#(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 8,
  parameter int SLOT_BYTES   = 8,
  parameter int ALIGN_BYTES  = 8,
  parameter int MAX_SLOTS    = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   mode,
  input  logic signed [KEY_W-1:0] level_index,
  input  logic signed [KEY_W-1:0] item_index,
  input  logic [REQ_W-1:0]    request_bytes,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [OFF_W-1:0]    byte_offset
);

  localparam int LB_W    = $clog2(PAGE_BYTES + 1);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int ALLOC_W = REQ_W + 1;
  localparam int A_W     = $clog2(ALIGN_BYTES + 1);
  // reciprocal for the round-up quotient, exact for ALLOC_W-bit numerators
  localparam int RND_SH  = 21;
  localparam int RECIP_W = RND_SH + 1;
  localparam int PROD_W  = ALLOC_W + RECIP_W;
  localparam int AP_W    = ALLOC_W + A_W;
  localparam int NEED_W  = $clog2(HEADER_BYTES + (MAX_SLOTS + 1) * SLOT_BYTES
                                  + (1 << ALLOC_W)) + 1;
  localparam int CMP_W   = (NEED_W > LB_W) ? NEED_W : LB_W;
  localparam int PG_W    = (REQ_W > LB_W) ? REQ_W : LB_W;

  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RND_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES);
  localparam logic [ALLOC_W-1:0] ALIGN_M1  = ALLOC_W'(ALIGN_BYTES - 1);
  localparam logic [A_W-1:0]     ALIGN_V   = A_W'(ALIGN_BYTES);
  localparam logic [CMP_W-1:0]   BASE_NEED = CMP_W'(HEADER_BYTES + SLOT_BYTES);
  localparam logic [CMP_W-1:0]   SLOT_V    = CMP_W'(SLOT_BYTES);
  localparam logic [CNT_W-1:0]   MAX_V     = CNT_W'(MAX_SLOTS);
  localparam logic [PG_W-1:0]    PAGE_V    = PG_W'(PAGE_BYTES);
  localparam logic [REQ_W-1:0]   HEADER_V  = REQ_W'(HEADER_BYTES);

  state_t state, state_next;

  // latched transaction
  mode_t            op;
  logic [KEY_W-1:0] key_level;
  logic [KEY_W-1:0] key_item;
  logic [REQ_W-1:0] req;

  logic [CNT_W-1:0]   slot_count;
  logic [LB_W-1:0]    low_bound;
  logic [ALLOC_W-1:0] quot;
  logic [ALLOC_W-1:0] alloc;
  logic [IDX_W-1:0]   scan_idx;
  logic [STATUS_W-1:0] res_status;
  logic [OFF_W-1:0]    res_offset;

  // combinational control
  logic                done;
  logic [STATUS_W-1:0] done_status;
  logic [OFF_W-1:0]    done_offset;
  logic                clear_do;
  logic                add_do;
  logic                wr_en;
  logic [IDX_W-1:0]    rd_addr;
  slot_entry_t         wr_data;
  slot_entry_t         rd_data;

  // datapath
  logic [ALLOC_W-1:0] rnd_sum;
  logic [PROD_W-1:0]  rnd_prod;
  logic [AP_W-1:0]    alloc_prod;
  logic [CMP_W-1:0]   need;
  logic [LB_W-1:0]    new_off;
  logic [PG_W-1:0]    req_ext;
  logic [LB_W-1:0]    page_size;
  logic               scan_hit;
  logic               scan_last;

  assign rnd_sum    = {1'b0, req} + ALIGN_M1;
  assign rnd_prod   = PROD_W'(rnd_sum) * PROD_W'(RECIP);
  assign alloc_prod = AP_W'(quot) * AP_W'(ALIGN_V);
  assign need       = BASE_NEED + CMP_W'(slot_count) * SLOT_V + CMP_W'(alloc);
  assign new_off    = low_bound - LB_W'(alloc);
  assign req_ext    = PG_W'(req);
  assign page_size  = (req_ext > PAGE_V) ? LB_W'(PAGE_V) : LB_W'(req_ext);
  assign scan_hit   = (rd_data.level == key_level) && (rd_data.item == key_item);
  assign scan_last  = (CNT_W'(scan_idx) + CNT_W'(1)) == slot_count;

  assign in_ready = (state == S_IDLE);

  assign wr_data.level  = key_level;
  assign wr_data.item   = key_item;
  assign wr_data.offset = OFF_W'(new_off);

  always_comb begin
    state_next  = state;
    done        = 1'b0;
    done_status = ST_NOT_FOUND;
    done_offset = '0;
    clear_do    = 1'b0;
    add_do      = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (mode_t'(mode) == MODE_ADD) ? S_ROUND : S_EXEC;
        end
      end
      S_ROUND: state_next = S_ALLOC;
      S_ALLOC: state_next = S_EXEC;
      S_EXEC: begin
        unique case (op)
          MODE_CLEAR: begin
            done = 1'b1;
            if (req < HEADER_V) begin
              done_status = ST_TOO_SMALL;
            end else begin
              done_status = ST_OK;
              clear_do    = 1'b1;
            end
          end
          MODE_ADD: begin
            done = 1'b1;
            priority if (req == '0) begin
              done_status = ST_ZERO_SIZE;
            end else if (slot_count >= MAX_V) begin
              done_status = ST_NO_SPACE;
            end else if (need > CMP_W'(low_bound)) begin
              done_status = ST_NO_SPACE;
            end else begin
              done_status = ST_OK;
              done_offset = OFF_W'(new_off);
              add_do      = 1'b1;
              wr_en       = 1'b1;
            end
          end
          MODE_LOOKUP: begin
            if (slot_count == '0) begin
              done = 1'b1;
            end else begin
              state_next = S_SCAN;
            end
          end
          MODE_NONE: done = 1'b1;
          default: done = 1'b1;
        endcase
        if (done) begin
          state_next = S_RESULT;
        end
      end
      S_SCAN: begin
        rd_addr = scan_idx + IDX_W'(1);
        if (scan_hit) begin
          done        = 1'b1;
          done_status = ST_OK;
          done_offset = rd_data.offset;
          state_next  = S_RESULT;
        end else if (scan_last) begin
          done       = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      slot_count <= '0;
      low_bound  <= '0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        op        <= mode_t'(mode);
        key_level <= level_index;
        key_item  <= item_index;
        req       <= request_bytes;
      end
      if (state == S_ROUND) begin
        quot <= rnd_prod[RND_SH +: ALLOC_W];
      end
      if (state == S_ALLOC) begin
        alloc <= alloc_prod[ALLOC_W-1:0];
      end
      if (clear_do) begin
        slot_count <= '0;
        low_bound  <= page_size;
      end
      if (add_do) begin
        slot_count <= slot_count + CNT_W'(1);
        low_bound  <= new_off;
      end
      if (state == S_EXEC) begin
        scan_idx <= '0;
      end else if (state == S_SCAN) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (done) begin
        res_status <= done_status;
        res_offset <= done_offset;
      end
      if (state == S_RESULT && (!out_valid || out_ready)) begin
        out_valid   <= 1'b1;
        status      <= res_status;
        byte_offset <= res_offset;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a lookup always follows the add that wrote its entries, so no forwarding is needed
  svp_dir_ram #(
    .DEPTH  (MAX_SLOTS),
    .ADDR_W (IDX_W)
  ) u_dir (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

/* sv/svp_checker.sv */
// port-level checks for the slotted value page, bound to the top level
// depends on svp_pkg and slotted_value_page_defines.svh
`include "slotted_value_page_defines.svh"

module svp_checker
  import svp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [OFF_W-1:0]    byte_offset
);

  `SVP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(byte_offset), "stalled result changed")
  `SVP_ASSERT_NOW(a_zero_offset, out_valid && status != ST_OK, byte_offset == '0, "offset not zero on failed transaction")
  `SVP_ASSERT_NEXT(a_single_item, in_valid && in_ready, !in_ready, "second transaction taken while busy")
  `SVP_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "result appeared one cycle after acceptance")

endmodule

bind slotted_value_page svp_checker u_svp_checker (.*);
